FILE: design/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg
// shared types, codes and character constants for the integer conversion core
// ----------------------------------------------------------------------------
package pic_pkg;

    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned OP_W      = 3;
    localparam int unsigned TUSER_W   = 8;
    localparam int unsigned NUM_DIGS  = 20;
    localparam int unsigned DIGS_W    = 4 * NUM_DIGS;
    localparam int unsigned DCNT_W    = $clog2(NUM_DIGS + 1);
    localparam int unsigned ITER_W    = $clog2(VALUE_W);

    typedef enum logic [OP_W-1:0] {
        OP_BYTE     = 3'd0,
        OP_SDEC     = 3'd1,
        OP_UDEC     = 3'd2,
        OP_HEX      = 3'd3,
        OP_PTR      = 3'd4,
        OP_UNKNOWN  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_PRE,
        S_BODY
    } t_state;

    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X       = 8'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_L       = 8'h6C;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else begin
            c = CH_UPPER_A + {4'd0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

FILE: design/printf_integer_conversion_core.sv
// ----------------------------------------------------------------------------
// printf_integer_conversion_core
// turns one conversion request into its ascii characters, last one marked
// ----------------------------------------------------------------------------
// One request is taken when the core is idle and its characters leave one per
// transaction through a registered output stage, leftmost first, tlast on the
// final one. Decimal requests run a shift-and-add-3 binary to bcd unit, one
// argument bit per cycle; hex, pointer and decimal then drop leading zeros one
// digit per cycle (at most 19), and the characters go out as the sink takes
// them. Undefined op codes are dropped without output.
// ----------------------------------------------------------------------------
module printf_integer_conversion_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [pic_pkg::VALUE_W-1:0]   i_s_axis_tdata,  // value
    input  logic [pic_pkg::TUSER_W-1:0]   i_s_axis_tuser,  // op[2:0], wide[3], zeros
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [pic_pkg::CHAR_W-1:0]    o_m_axis_tdata,  // character
    output logic                          o_m_axis_tlast
);

    pic_pkg::t_state                  r_state, n_state;
    logic [pic_pkg::VALUE_W-1:0]      r_bin, n_bin;
    logic [pic_pkg::DIGS_W-1:0]       r_digs, n_digs;
    logic [pic_pkg::ITER_W-1:0]       r_iter, n_iter;
    logic [pic_pkg::DCNT_W-1:0]       r_cnt, n_cnt;
    logic [2*pic_pkg::CHAR_W-1:0]     r_pre, n_pre;
    logic [1:0]                       r_pre_cnt, n_pre_cnt;
    logic                             r_lit, n_lit;
    logic [pic_pkg::CHAR_W-1:0]       r_lit_ch, n_lit_ch;
    logic                             r_valid, n_valid;
    logic [pic_pkg::CHAR_W-1:0]       r_data, n_data;
    logic                             r_last, n_last;

    logic                             in_acc;
    logic                             slot_free;
    logic [pic_pkg::OP_W-1:0]         op;
    logic                             wide;
    logic [pic_pkg::VALUE_W-1:0]      raw;
    logic [pic_pkg::VALUE_W-1:0]      sval;
    logic [pic_pkg::VALUE_W-1:0]      uval;
    logic [pic_pkg::VALUE_W-1:0]      mag;
    logic [pic_pkg::DIGS_W-1:0]       adj;

    assign op        = i_s_axis_tuser[pic_pkg::OP_W-1:0];
    assign wide      = i_s_axis_tuser[pic_pkg::OP_W];
    assign raw       = i_s_axis_tdata;
    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free = !r_valid || i_m_axis_tready;

    assign sval = wide ? raw : {{32{raw[31]}}, raw[31:0]};
    assign uval = wide ? raw : {32'd0, raw[31:0]};
    assign mag  = sval[pic_pkg::VALUE_W-1] ? (~sval + 64'd1) : sval;

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < pic_pkg::NUM_DIGS; i++) begin
            adj[4*i +: 4] = (r_digs[4*i +: 4] >= 4'd5) ? r_digs[4*i +: 4] + 4'd3
                                                        : r_digs[4*i +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pic_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_bin     <= n_bin;
        r_digs    <= n_digs;
        r_iter    <= n_iter;
        r_cnt     <= n_cnt;
        r_pre     <= n_pre;
        r_pre_cnt <= n_pre_cnt;
        r_lit     <= n_lit;
        r_lit_ch  <= n_lit_ch;
        r_data    <= n_data;
        r_last    <= n_last;
    end

    always_comb begin
        n_state   = r_state;
        n_bin     = r_bin;
        n_digs    = r_digs;
        n_iter    = r_iter;
        n_cnt     = r_cnt;
        n_pre     = r_pre;
        n_pre_cnt = r_pre_cnt;
        n_lit     = r_lit;
        n_lit_ch  = r_lit_ch;
        n_valid   = r_valid && !i_m_axis_tready;
        n_data    = r_data;
        n_last    = r_last;
        o_s_axis_tready = (r_state == pic_pkg::S_IDLE);

        case (r_state)
            pic_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_lit     = 1'b0;
                    n_lit_ch  = raw[pic_pkg::CHAR_W-1:0];
                    n_pre     = '0;
                    n_pre_cnt = 2'd0;
                    n_bin     = uval;
                    n_digs    = '0;
                    n_iter    = '0;
                    n_cnt     = pic_pkg::DCNT_W'(pic_pkg::NUM_DIGS);
                    case (op)
                        pic_pkg::OP_BYTE: begin
                            n_lit   = 1'b1;
                            n_state = pic_pkg::S_PRE;
                        end
                        pic_pkg::OP_SDEC: begin
                            n_bin = mag;
                            if (sval[pic_pkg::VALUE_W-1]) begin
                                n_pre     = {8'd0, pic_pkg::CH_MINUS};
                                n_pre_cnt = 2'd1;
                            end
                            n_state = pic_pkg::S_CONV;
                        end
                        pic_pkg::OP_UDEC: begin
                            n_state = pic_pkg::S_CONV;
                        end
                        pic_pkg::OP_HEX: begin
                            n_digs  = {16'd0, uval};
                            n_state = pic_pkg::S_SKIP;
                        end
                        pic_pkg::OP_PTR: begin
                            n_digs    = {16'd0, raw};
                            n_pre     = {pic_pkg::CH_X, pic_pkg::CH_ZERO};
                            n_pre_cnt = 2'd2;
                            n_state   = pic_pkg::S_SKIP;
                        end
                        pic_pkg::OP_UNKNOWN: begin
                            n_lit     = 1'b1;
                            n_pre     = {pic_pkg::CH_L, pic_pkg::CH_PERCENT};
                            n_pre_cnt = wide ? 2'd2 : 2'd1;
                            n_state   = pic_pkg::S_PRE;
                        end
                        default: begin
                            n_state = pic_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            pic_pkg::S_CONV: begin
                n_digs = {adj[pic_pkg::DIGS_W-2:0], r_bin[pic_pkg::VALUE_W-1]};
                n_bin  = {r_bin[pic_pkg::VALUE_W-2:0], 1'b0};
                n_iter = r_iter + 1'b1;
                if (r_iter == pic_pkg::ITER_W'(pic_pkg::VALUE_W - 1)) begin
                    n_state = pic_pkg::S_SKIP;
                end
            end
            pic_pkg::S_SKIP: begin
                if (r_digs[pic_pkg::DIGS_W-1 -: 4] == 4'd0 && r_cnt > 1) begin
                    n_digs = {r_digs[pic_pkg::DIGS_W-5:0], 4'd0};
                    n_cnt  = r_cnt - 1'b1;
                end else begin
                    n_state = pic_pkg::S_PRE;
                end
            end
            pic_pkg::S_PRE: begin
                if (r_pre_cnt == 2'd0) begin
                    n_state = pic_pkg::S_BODY;
                end else if (slot_free) begin
                    n_valid   = 1'b1;
                    n_data    = r_pre[pic_pkg::CHAR_W-1:0];
                    n_last    = 1'b0;
                    n_pre     = {8'd0, r_pre[2*pic_pkg::CHAR_W-1:pic_pkg::CHAR_W]};
                    n_pre_cnt = r_pre_cnt - 1'b1;
                end
            end
            pic_pkg::S_BODY: begin
                if (slot_free) begin
                    n_valid = 1'b1;
                    n_data  = r_lit ? r_lit_ch
                                    : pic_pkg::digit_char(r_digs[pic_pkg::DIGS_W-1 -: 4]);
                    n_last  = r_lit || (r_cnt == 1);
                    n_digs  = {r_digs[pic_pkg::DIGS_W-5:0], 4'd0};
                    n_cnt   = r_cnt - 1'b1;
                    if (r_lit || r_cnt == 1) begin
                        n_state = pic_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = pic_pkg::S_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_data;
    assign o_m_axis_tlast  = r_last;

endmodule

FILE: design/pic_checker.sv
// ----------------------------------------------------------------------------
// pic_checker
// port-level checks on the integer conversion core
// ----------------------------------------------------------------------------
module pic_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    input  logic                          o_s_axis_tready,
    input  logic [pic_pkg::VALUE_W-1:0]   i_s_axis_tdata,  // value
    input  logic [pic_pkg::TUSER_W-1:0]   i_s_axis_tuser,  // op[2:0], wide[3], zeros
    input  logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [pic_pkg::CHAR_W-1:0]    o_m_axis_tdata,  // character
    input  logic                          o_m_axis_tlast
);

    logic defined_op;
    assign defined_op = (i_s_axis_tuser[pic_pkg::OP_W-1:0] <= pic_pkg::OP_UNKNOWN);

    // a defined request keeps the core busy afterwards
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && defined_op) |=> !o_s_axis_tready)
        else $error("core ready right after a defined request");

    // characters appear only while a request is in progress
    a_output_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("output started while core was idle");

    // a stalled character holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("output transaction changed under stall");

endmodule

bind printf_integer_conversion_core pic_checker u_pic_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
